>>> design/mecanum_odo_pkg.sv
// Shared types, constants and tables for the mecanum odometry integrator.
// Depends on nothing; imported by the controller, datapath and top level.
package mecanum_odo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_BITS   = 16;

  localparam logic [31:0] KEEP_MASK   = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
  localparam logic [4:0]  LAST_ITER   = 5'(CORDIC_STEPS - 1);
  localparam logic signed [32:0] VEL_K       = 33'sd90249485;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // configuration register indexes
  localparam logic [1:0] REG_TIME_STEP = 2'd0;
  localparam logic [1:0] REG_SLIP_GAIN = 2'd1;

  localparam logic [31:0] TIME_STEP_RST = 32'd21475;
  localparam logic [15:0] SLIP_GAIN_RST = 16'd4608;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_WSX, MUL_WSY, MUL_VXC, MUL_VYS, MUL_VXS, MUL_VYC,
    MUL_MXT, MUL_MYT, MUL_RT, MUL_XH, MUL_XL, MUL_YH, MUL_YL
  } mul_op_t;

  typedef enum logic [3:0] {
    SNK_NONE, SNK_VX, SNK_VY, SNK_SUM, SNK_MX, SNK_MY,
    SNK_ACCX, SNK_ACCY, SNK_ACCT, SNK_POSX
  } sink_t;

  typedef struct packed {
    logic       load;
    mul_op_t    mul_op;
    sink_t      sink;
    logic       cordic_step;
    logic       cordic_fin;
    logic       out_load;
    logic [4:0] iter;
  } odo_cmd_t;

  // arctangent of 2^-i in 2^32-per-turn units
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;  5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;  5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;  5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;  5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;  5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;  5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;  5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;  5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;  5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;  5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;  5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;  5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;  5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;  5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;  5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) r = 32'h7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> design/mecanum_odo_ctrl.sv
// Sequencer for the odometry datapath: handshakes, step order, CORDIC count.
// Depends on mecanum_odo_pkg.
module mecanum_odo_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mecanum_odo_pkg::odo_cmd_t cmd
);
  import mecanum_odo_pkg::*;

  typedef enum logic [16:0] {
    ST_IDLE = 17'h00001, ST_VX  = 17'h00002, ST_VY  = 17'h00004,
    ST_CORD = 17'h00008, ST_CFIN = 17'h00010, ST_MXC = 17'h00020,
    ST_MXS  = 17'h00040, ST_MYS = 17'h00080, ST_MYC = 17'h00100,
    ST_DTX  = 17'h00200, ST_DTY = 17'h00400, ST_DTT = 17'h00800,
    ST_GXH  = 17'h01000, ST_GXL = 17'h02000, ST_GYH = 17'h04000,
    ST_GYL  = 17'h08000, ST_OUT = 17'h10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] iter_r, iter_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt       = state_r;
    iter_nxt        = iter_r;
    cmd             = '0;
    cmd.mul_op      = MUL_NONE;
    cmd.sink        = SNK_NONE;
    cmd.iter        = iter_r;
    case (state_r)
      ST_IDLE: begin
        cmd.load = in_valid;
        iter_nxt = '0;
        if (in_valid) state_nxt = ST_VX;
      end
      ST_VX: begin
        cmd.mul_op = MUL_WSX;
        state_nxt  = ST_VY;
      end
      ST_VY: begin
        cmd.sink   = SNK_VX;
        cmd.mul_op = MUL_WSY;
        state_nxt  = ST_CORD;
      end
      ST_CORD: begin
        cmd.sink        = SNK_VY;
        cmd.cordic_step = 1'b1;
        iter_nxt        = iter_r + 5'd1;
        if (iter_r == LAST_ITER) state_nxt = ST_CFIN;
      end
      ST_CFIN: begin
        cmd.cordic_fin = 1'b1;
        state_nxt      = ST_MXC;
      end
      ST_MXC: begin
        cmd.mul_op = MUL_VXC;
        state_nxt  = ST_MXS;
      end
      ST_MXS: begin
        cmd.sink = SNK_SUM; cmd.mul_op = MUL_VYS; state_nxt = ST_MYS;
      end
      ST_MYS: begin
        cmd.sink = SNK_MX;  cmd.mul_op = MUL_VXS; state_nxt = ST_MYC;
      end
      ST_MYC: begin
        cmd.sink = SNK_SUM; cmd.mul_op = MUL_VYC; state_nxt = ST_DTX;
      end
      ST_DTX: begin
        cmd.sink = SNK_MY;   cmd.mul_op = MUL_MXT; state_nxt = ST_DTY;
      end
      ST_DTY: begin
        cmd.sink = SNK_ACCX; cmd.mul_op = MUL_MYT; state_nxt = ST_DTT;
      end
      ST_DTT: begin
        cmd.sink = SNK_ACCY; cmd.mul_op = MUL_RT;  state_nxt = ST_GXH;
      end
      ST_GXH: begin
        cmd.sink = SNK_ACCT; cmd.mul_op = MUL_XH;  state_nxt = ST_GXL;
      end
      ST_GXL: begin
        cmd.sink = SNK_SUM;  cmd.mul_op = MUL_XL;  state_nxt = ST_GYH;
      end
      ST_GYH: begin
        cmd.sink = SNK_POSX; cmd.mul_op = MUL_YH;  state_nxt = ST_GYL;
      end
      ST_GYL: begin
        cmd.sink = SNK_SUM;  cmd.mul_op = MUL_YL;  state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        cmd.out_load = out_free;
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("controller state not one-hot");
  a_cord_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CORD && iter_r == LAST_ITER) |=> state_r == ST_CFIN)
    else $error("CORDIC run did not end after its last step");
  a_out_set: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result loaded but not presented");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.out_load)
    else $error("result overwritten while waiting");

endmodule

>>> design/mecanum_odo_dp.sv
// Datapath: input capture, CORDIC, shared 33x33 multiplier, accumulators,
// output scaling and result register. Depends on mecanum_odo_pkg.
module mecanum_odo_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mecanum_odo_pkg::odo_cmd_t cmd,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [31:0]               cfg_wdata,
  input  logic signed [15:0]        in_wheel_one_rpm,
  input  logic signed [15:0]        in_wheel_two_rpm,
  input  logic signed [15:0]        in_wheel_three_rpm,
  input  logic signed [15:0]        in_wheel_four_rpm,
  input  logic [15:0]               in_heading_angle,
  input  logic signed [15:0]        in_rotate_rate,
  output logic signed [31:0]        out_position_x,
  output logic signed [31:0]        out_position_y,
  output logic signed [31:0]        out_heading_command
);
  import mecanum_odo_pkg::*;

  logic [31:0]        time_step_r;
  logic [15:0]        slip_gain_r;
  logic signed [18:0] wsx_r, wsy_r;
  logic signed [15:0] rate_r;
  logic signed [33:0] x_r, y_r;
  logic signed [32:0] z_r;
  logic               flip_r;
  logic signed [29:0] vx_r, vy_r, mx_r, my_r;
  logic signed [65:0] sum_r, prod_r;
  logic [63:0]        accx_r, accy_r, acct_r;
  logic [31:0]        posx_r;
  logic [31:0]        out_x_r, out_y_r, out_t_r;

  logic [31:0]        phase, phase_f;
  logic               flip;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] sum_p;
  logic signed [33:0] dx, dy;
  logic [31:0]        atan;
  logic [31:0]        pos_new;

  // quantise heading and fold the left half plane
  always_comb begin
    phase   = {in_heading_angle, 16'h0000} & KEEP_MASK;
    flip    = phase[31] ^ phase[30];
    phase_f = flip ? (phase ^ 32'h80000000) : phase;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      MUL_WSX: begin mul_a = 33'(wsx_r); mul_b = VEL_K; end
      MUL_WSY: begin mul_a = 33'(wsy_r); mul_b = VEL_K; end
      MUL_VXC: begin mul_a = 33'(vx_r);  mul_b = x_r[32:0]; end
      MUL_VYS: begin mul_a = 33'(vy_r);  mul_b = y_r[32:0]; end
      MUL_VXS: begin mul_a = 33'(vx_r);  mul_b = y_r[32:0]; end
      MUL_VYC: begin mul_a = 33'(vy_r);  mul_b = x_r[32:0]; end
      MUL_MXT: begin mul_a = 33'(mx_r);  mul_b = {1'b0, time_step_r}; end
      MUL_MYT: begin mul_a = 33'(my_r);  mul_b = {1'b0, time_step_r}; end
      MUL_RT:  begin mul_a = 33'(rate_r); mul_b = {1'b0, time_step_r}; end
      MUL_XH:  begin mul_a = {accx_r[63], accx_r[63:32]}; mul_b = {17'd0, slip_gain_r}; end
      MUL_XL:  begin mul_a = {1'b0, accx_r[31:0]};        mul_b = {17'd0, slip_gain_r}; end
      MUL_YH:  begin mul_a = {accy_r[63], accy_r[63:32]}; mul_b = {17'd0, slip_gain_r}; end
      MUL_YL:  begin mul_a = {1'b0, accy_r[31:0]};        mul_b = {17'd0, slip_gain_r}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign sum_p = sum_r + prod_r;
  assign dx    = x_r >>> cmd.iter;
  assign dy    = y_r >>> cmd.iter;
  assign atan  = atan_turn(cmd.iter);
  // high word times gain, shifted, plus the fraction's carry-in
  assign pos_new = sat32({sum_r[55:0], 8'h00} + {40'd0, prod_r[47:24]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= TIME_STEP_RST;
      slip_gain_r <= SLIP_GAIN_RST;
      accx_r      <= '0;
      accy_r      <= '0;
      acct_r      <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_TIME_STEP) time_step_r <= cfg_wdata;
      if (cfg_we && cfg_index == REG_SLIP_GAIN) slip_gain_r <= cfg_wdata[15:0];
      case (cmd.sink)
        SNK_ACCX: accx_r <= accx_r + {{14{prod_r[65]}}, prod_r[65:16]};
        SNK_ACCY: accy_r <= accy_r + {{14{prod_r[65]}}, prod_r[65:16]};
        SNK_ACCT: acct_r <= acct_r + prod_r[63:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wsx_r  <= 19'(in_wheel_one_rpm) + 19'(in_wheel_two_rpm)
              - 19'(in_wheel_three_rpm) - 19'(in_wheel_four_rpm);
      wsy_r  <= 19'(in_wheel_one_rpm) - 19'(in_wheel_two_rpm)
              - 19'(in_wheel_three_rpm) + 19'(in_wheel_four_rpm);
      rate_r <= in_rotate_rate;
      x_r    <= CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= 33'(signed'(phase_f));
      flip_r <= flip;
    end else if (cmd.cordic_step) begin
      if (!z_r[32]) begin
        x_r <= x_r - dy;
        y_r <= y_r + dx;
        z_r <= z_r - {1'b0, atan};
      end else begin
        x_r <= x_r + dy;
        y_r <= y_r - dx;
        z_r <= z_r + {1'b0, atan};
      end
    end else if (cmd.cordic_fin && flip_r) begin
      x_r <= -x_r;
      y_r <= -y_r;
    end

    if (cmd.mul_op != MUL_NONE) prod_r <= mul_a * mul_b;

    case (cmd.sink)
      SNK_VX:   vx_r   <= prod_r[45:16];
      SNK_VY:   vy_r   <= prod_r[45:16];
      SNK_SUM:  sum_r  <= prod_r;
      SNK_MX:   mx_r   <= sum_p[59:30];
      SNK_MY:   my_r   <= sum_p[59:30];
      SNK_POSX: posx_r <= pos_new;
      default: ;
    endcase

    if (cmd.out_load) begin
      out_x_r <= posx_r;
      out_y_r <= pos_new;
      out_t_r <= sat32({{16{acct_r[63]}}, acct_r[63:16]});
    end
  end

  assign out_position_x      = out_x_r;
  assign out_position_y      = out_y_r;
  assign out_heading_command = out_t_r;

endmodule

>>> design/mecanum_odometry_integrator.sv
// Top level of the mecanum odometry integrator: controller plus datapath.
// Depends on mecanum_odo_pkg, mecanum_odo_ctrl and mecanum_odo_dp.
//
// One transaction in gives one transaction out. Each tick takes four wheel
// speeds, a heading and a rotate command, forms body velocities, mixes them
// by the heading's sine and cosine (16-step CORDIC, one step per cycle),
// integrates into 64-bit Q32.32 accumulators and returns saturated Q16.16
// position and heading command. From acceptance to the output register an
// item goes through a capture step, two multiplier passes for the
// velocities, 16 CORDIC steps, a fold-back step, eleven further passes
// through the single shared 33x33 multiplier and a step that loads the output
// register. The next item is accepted as soon as the result is in the output
// register, even if it is still waiting there; a result that waits stalls
// the following item only in its output-load step.
// Configuration writes (time_step, slip_gain) take effect at once and must
// only be made while the block is idle.
module mecanum_odometry_integrator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_wheel_one_rpm,
  input  logic signed [15:0] in_wheel_two_rpm,
  input  logic signed [15:0] in_wheel_three_rpm,
  input  logic signed [15:0] in_wheel_four_rpm,
  input  logic [15:0]        in_heading_angle,
  input  logic signed [15:0] in_rotate_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_position_x,
  output logic signed [31:0] out_position_y,
  output logic signed [31:0] out_heading_command,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import mecanum_odo_pkg::*;

  odo_cmd_t cmd;

  // sequence the steps and own both handshakes
  mecanum_odo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // arithmetic, state and result register
  mecanum_odo_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_wheel_one_rpm    (in_wheel_one_rpm),
    .in_wheel_two_rpm    (in_wheel_two_rpm),
    .in_wheel_three_rpm  (in_wheel_three_rpm),
    .in_wheel_four_rpm   (in_wheel_four_rpm),
    .in_heading_angle    (in_heading_angle),
    .in_rotate_rate      (in_rotate_rate),
    .out_position_x      (out_position_x),
    .out_position_y      (out_position_y),
    .out_heading_command (out_heading_command)
  );

endmodule

>>> tb/mecanum_odometry_integrator_tb.sv
// Self-checking bench for mecanum_odometry_integrator: random and directed odometry ticks,
// checked against a bit-exact in-bench prediction of integrated position and heading command.
// Depends on mecanum_odo_pkg and the design sources.
`timescale 1ns / 100ps

module mecanum_odometry_integrator_tb;
  import mecanum_odo_pkg::*;

  typedef struct packed {
    logic signed [15:0] w1, w2, w3, w4;
    logic [15:0]        heading;
    logic signed [15:0] rate;
  } tick_t;

  typedef struct packed {
    logic signed [31:0] pos_x, pos_y, turn;
  } pose_t;

  localparam int LIMIT_CYCLES = 400000;
  // register index with no register behind it
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_wheel_one_rpm = '0, in_wheel_two_rpm = '0;
  logic signed [15:0] in_wheel_three_rpm = '0, in_wheel_four_rpm = '0;
  logic [15:0] in_heading_angle = '0;
  logic signed [15:0] in_rotate_rate = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_position_x, out_position_y, out_heading_command;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  // predictor state: configuration and Q32.32 accumulators
  logic [31:0] dt_q032;
  logic [15:0] gain_q88;
  logic [63:0] acc_x, acc_y, acc_turn;

  tick_t pending_ticks[$];
  pose_t expected_poses[$];
  int    errors = 0;
  int    ticks_sent = 0;
  int    poses_seen = 0;
  int    cycle_count = 0;
  bit    calm = 1'b0;     // no idling in the closing stretch
  int    drv_gap = 0;
  int    snk_gap = 0;
  // acceptance flag sampled at the rising edge, seen by the driver
  bit    in_accepted = 1'b0;

  mecanum_odometry_integrator u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // rotation-mode CORDIC in Q2.30, left half plane folded over
  task automatic heading_sin_cos(input logic [15:0] hd, output longint c, output longint s);
    logic [31:0] ph;
    bit flip;
    longint x, y, z, dx, dy;
    ph = {hd, 16'h0} & KEEP_MASK;
    flip = ph[31] ^ ph[30];
    if (flip) ph = ph - 32'h80000000;
    z = longint'($signed(ph));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (z >= 0) begin
        x -= dy; y += dx; z -= longint'(atan_turn(5'(i)));
      end else begin
        x += dy; y -= dx; z += longint'(atan_turn(5'(i)));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  function automatic logic [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'h7FFFFFFF;
    if (v < -128'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] scale_position(input logic [63:0] acc);
    logic signed [127:0] p;
    p = ($signed({{64{acc[63]}}, acc}) * $signed({112'd0, gain_q88})) >>> 24;
    return clamp32(p);
  endfunction

  task automatic integrate_tick(input tick_t t);
    longint c, s, vx, vy, mx, my, dt;
    logic signed [127:0] wide;
    pose_t p;
    dt = longint'(dt_q032);
    vx = ((longint'(t.w1) + t.w2 - t.w3 - t.w4) * 90249485) >>> 16;
    vy = ((longint'(t.w1) - t.w2 - t.w3 + t.w4) * 90249485) >>> 16;
    heading_sin_cos(t.heading, c, s);
    mx = (vx * c + vy * s) >>> 30;
    my = (vx * s + vy * c) >>> 30;
    acc_x += 64'((mx * dt) >>> 16);
    acc_y += 64'((my * dt) >>> 16);
    acc_turn += 64'(longint'(t.rate) * dt);
    p.pos_x = scale_position(acc_x);
    p.pos_y = scale_position(acc_y);
    wide = $signed({{64{acc_turn[63]}}, acc_turn}) >>> 16;
    p.turn = clamp32(wide);
    expected_poses.push_back(p);
  endtask

  // driver: present the head of the queue, hold until accepted
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_accepted) begin
        if (drv_gap > 0) begin
          drv_gap <= drv_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          tick_t t;
          t = pending_ticks.pop_front();
          in_wheel_one_rpm <= t.w1;
          in_wheel_two_rpm <= t.w2;
          in_wheel_three_rpm <= t.w3;
          in_wheel_four_rpm <= t.w4;
          in_heading_angle <= t.heading;
          in_rotate_rate <= t.rate;
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) drv_gap <= $urandom_range(1, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 6) == 0) snk_gap <= $urandom_range(1, 13);
      end
    end
  end

  // monitor: predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_accepted <= 1'b0;
    if (rst_n && in_valid && in_ready) begin
      tick_t t;
      t = {in_wheel_one_rpm, in_wheel_two_rpm, in_wheel_three_rpm, in_wheel_four_rpm,
           in_heading_angle, in_rotate_rate};
      integrate_tick(t);
      ticks_sent <= ticks_sent + 1;
      in_accepted <= 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      pose_t got, want;
      got = {out_position_x, out_position_y, out_heading_command};
      poses_seen <= poses_seen + 1;
      if (expected_poses.size() == 0) begin
        $display("%0t: unexpected pose x=%0d y=%0d turn=%0d", $realtime,
                 got.pos_x, got.pos_y, got.turn);
        errors++;
      end else begin
        want = expected_poses.pop_front();
        if (got.pos_x !== want.pos_x) begin
          $display("%0t: position_x expected %0d got %0d", $realtime, want.pos_x, got.pos_x);
          errors++;
        end
        if (got.pos_y !== want.pos_y) begin
          $display("%0t: position_y expected %0d got %0d", $realtime, want.pos_y, got.pos_y);
          errors++;
        end
        if (got.turn !== want.turn) begin
          $display("%0t: heading_command expected %0d got %0d", $realtime,
                   want.turn, got.turn);
          errors++;
        end
      end
    end
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d poses outstanding", $realtime, expected_poses.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // write one register at a falling edge, mirror it in the predictor
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TIME_STEP) dt_q032 = val;
    else if (idx == REG_SLIP_GAIN) gain_q88 = val[15:0];
  endtask

  // wait until every queued tick has gone out and every pose come back
  task automatic drain();
    while (pending_ticks.size() > 0 || in_valid || expected_poses.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic tick_t random_tick(input int spread);
    tick_t t;
    t.heading = 16'($urandom);
    if (spread == 0) begin
      t.w1 = 16'($urandom); t.w2 = 16'($urandom);
      t.w3 = 16'($urandom); t.w4 = 16'($urandom);
      t.rate = 16'($urandom);
    end else begin
      t.w1 = 16'($urandom_range(0, 2 * spread) - spread);
      t.w2 = 16'($urandom_range(0, 2 * spread) - spread);
      t.w3 = 16'($urandom_range(0, 2 * spread) - spread);
      t.w4 = 16'($urandom_range(0, 2 * spread) - spread);
      t.rate = 16'($urandom_range(0, 2 * spread) - spread);
    end
    return t;
  endfunction

  initial begin
    tick_t t;
    logic [31:0] dts[5];
    logic [15:0] gains[5];
    dt_q032 = TIME_STEP_RST;
    gain_q88 = SLIP_GAIN_RST;
    acc_x = '0; acc_y = '0; acc_turn = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, every quadrant edge of the heading, pure rotation
    foreach (dts[i]) dts[i] = 0;
    t = '0; pending_ticks.push_back(t);
    t = {16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'h0000, 16'sh7FFF};
    pending_ticks.push_back(t);
    t = {16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'sh8000};
    pending_ticks.push_back(t);
    t = {16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'h4000, 16'sh0001};
    pending_ticks.push_back(t);
    foreach (dts[i]) begin
      t = {16'sd1000, -16'sd300, 16'sd50, 16'sd700, 16'(16'h4000 * i - (i > 0)), 16'sd5};
      pending_ticks.push_back(t);
      t.heading = 16'(16'h4000 * i + 1);
      pending_ticks.push_back(t);
    end
    t = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hC000, 16'hFFFF};
    pending_ticks.push_back(t);
    drain();

    // zero time step: no motion; zero gain: positions read zero
    write_reg(REG_TIME_STEP, 32'd0);
    write_reg(REG_SLIP_GAIN, 32'd0);
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);   // out of range, ignored
    repeat (4) pending_ticks.push_back(random_tick(0));
    drain();

    // sweep settings, extremes included; big steps drive saturation and wrap
    dts = '{32'hFFFF_FFFF, 32'h0100_0000, 32'd21475, 32'h0000_0001, 32'h8000_0000};
    gains = '{16'hFFFF, 16'h0001, 16'd4608, 16'h8000, 16'h0100};
    foreach (dts[p]) begin
      write_reg(REG_TIME_STEP, dts[p]);
      write_reg(REG_SLIP_GAIN, 32'(gains[p]));
      if (p == 4) calm = 1'b1;
      for (int k = 0; k < 120; k++) begin
        case ($urandom_range(0, 3))
          0: pending_ticks.push_back(random_tick(0));
          1: pending_ticks.push_back(random_tick(20));
          default: pending_ticks.push_back(random_tick(3000));
        endcase
      end
      drain();
    end

    $display("Covered %0d ticks and %0d poses over seven register settings,", ticks_sent,
             poses_seen);
    $display("including zero and full-scale time step and slip gain.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> mecanum_odometry_integrator.f
design/mecanum_odo_pkg.sv
design/mecanum_odo_ctrl.sv
design/mecanum_odo_dp.sv
design/mecanum_odometry_integrator.sv
tb/mecanum_odometry_integrator_tb.sv
